// File: design/grid_neighbourhood_weighted_deposit_macros.svh
// Assertion macros for the grid neighbourhood deposit block.
// Included by files that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef GRID_NEIGHBOURHOOD_WEIGHTED_DEPOSIT_MACROS_SVH
`define GRID_NEIGHBOURHOOD_WEIGHTED_DEPOSIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GNWD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnwd check failed");
// next-cycle implication
`define GNWD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnwd check failed");
`else
`define GNWD_ASSERT_IMP(lbl, ante, cons)
`define GNWD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/gnwd_pkg.sv
// Package for the grid neighbourhood deposit block: widths, register indexes,
// fixed-point constants and the neighbour slot helpers. No dependencies.
`timescale 1ns / 1ps

package gnwd_pkg;

    // default grid storage
    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;
    localparam int unsigned COORD_SPAN     = 256;

    // field widths
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned SIZE_W     = 9;
    localparam int unsigned STRENGTH_W = 16;
    localparam int unsigned FERT_W     = 16;
    localparam int unsigned WATER_W    = 16;
    localparam int unsigned DENSITY_W  = 32;

    // configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = 9'd256;

    // shared multiplier
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // effective fertility: floor(f0 * (1280 + water) / 1280), capped at 1.0 in Q2.14
    localparam int unsigned WATER_TERM_W = 17;
    localparam int unsigned EFF_W        = 15;
    localparam int unsigned Q_W          = 24;
    localparam int unsigned EFF_Q_SHIFT  = 8;
    localparam logic [WATER_TERM_W-1:0] EFF_DEN   = 17'd1280;
    localparam logic [Q_W-1:0]          EFF_SAT_Q = 24'd81920;
    localparam logic [EFF_W-1:0]        EFF_ONE   = 15'd16384;

    // divide by five through reciprocals; exact over the ranges used here
    localparam int unsigned RECIP5_19_SHIFT = 19;
    localparam int unsigned RECIP5_26_SHIFT = 26;
    localparam logic [MUL_B_W-1:0] RECIP5_19 = 24'd104858;
    localparam logic [MUL_B_W-1:0] RECIP5_26 = 24'd13421773;
    localparam logic [MUL_B_W-1:0] EDGE_TRIPLE = 24'd3;

    // increment per weight: base/1024, 3*base/5120, base/2560
    localparam int unsigned BASE_W      = 30;
    localparam int unsigned INC_W       = 20;
    localparam int unsigned INC_SHIFT   = 10;
    localparam int unsigned DIAG_SHIFT  = 9;
    localparam int unsigned TRIPLE_W    = 22;

    // neighbour slots in update order
    localparam int unsigned NUM_SLOTS = 9;
    localparam int unsigned SLOT_W    = 4;
    localparam logic [SLOT_W-1:0] SLOT_CENTRE      = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_ABOVE       = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_ABOVE_LEFT  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_ABOVE_RIGHT = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_BELOW       = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_BELOW_LEFT  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_BELOW_RIGHT = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_LEFT        = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT       = 4'd8;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef enum logic [1:0] {
        WT_CENTRE,
        WT_EDGE,
        WT_DIAG
    } weight_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } cell_t;

    // weight class of a slot
    function automatic weight_t slot_weight(logic [SLOT_W-1:0] slot);
        weight_t w;
        unique case (slot)
            SLOT_CENTRE:                          w = WT_CENTRE;
            SLOT_ABOVE, SLOT_BELOW,
            SLOT_LEFT, SLOT_RIGHT:                w = WT_EDGE;
            SLOT_ABOVE_LEFT, SLOT_ABOVE_RIGHT,
            SLOT_BELOW_LEFT, SLOT_BELOW_RIGHT:    w = WT_DIAG;
            default:                              w = WT_CENTRE;
        endcase
        return w;
    endfunction

    // cell addressed by a slot around the centre
    function automatic cell_t slot_cell(logic [SLOT_W-1:0] slot,
                                        logic [COORD_W-1:0] x,
                                        logic [COORD_W-1:0] y);
        cell_t c;
        logic [COORD_W-1:0] xm;
        logic [COORD_W-1:0] xp;
        logic [COORD_W-1:0] ym;
        logic [COORD_W-1:0] yp;
        xm = x - COORD_W'(1);
        xp = x + COORD_W'(1);
        ym = y - COORD_W'(1);
        yp = y + COORD_W'(1);
        unique case (slot)
            SLOT_CENTRE:      c = '{col: x,  row: y};
            SLOT_ABOVE:       c = '{col: x,  row: ym};
            SLOT_ABOVE_LEFT:  c = '{col: xm, row: ym};
            SLOT_ABOVE_RIGHT: c = '{col: xp, row: ym};
            SLOT_BELOW:       c = '{col: x,  row: yp};
            SLOT_BELOW_LEFT:  c = '{col: xm, row: yp};
            SLOT_BELOW_RIGHT: c = '{col: xp, row: yp};
            SLOT_LEFT:        c = '{col: xm, row: y};
            SLOT_RIGHT:       c = '{col: xp, row: y};
            default:          c = '{col: x,  row: y};
        endcase
        return c;
    endfunction

    // lowest pending slot
    function automatic logic [SLOT_W-1:0] first_slot(slot_mask_t m);
        logic [SLOT_W-1:0] s;
        s = SLOT_CENTRE;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                s = SLOT_W'(i);
            end
        end
        return s;
    endfunction

    // slots that fall inside the grid
    function automatic slot_mask_t neighbour_mask(logic up, logic down,
                                                  logic left, logic right);
        slot_mask_t m;
        m = '0;
        m[SLOT_CENTRE]      = 1'b1;
        m[SLOT_ABOVE]       = up;
        m[SLOT_ABOVE_LEFT]  = up & left;
        m[SLOT_ABOVE_RIGHT] = up & right;
        m[SLOT_BELOW]       = down;
        m[SLOT_BELOW_LEFT]  = down & left;
        m[SLOT_BELOW_RIGHT] = down & right;
        m[SLOT_LEFT]        = left;
        m[SLOT_RIGHT]       = right;
        return m;
    endfunction

endpackage

// File: design/grid_neighbourhood_weighted_deposit.sv
// Grid neighbourhood weighted deposit: top level with sequencer, shared multiplier
// and density memory. Depends on gnwd_pkg and grid_neighbourhood_weighted_deposit_macros.svh.
`timescale 1ns / 1ps

`include "grid_neighbourhood_weighted_deposit_macros.svh"

// After reset the block runs a clearing pass over the density memory, writing
// one word per cycle to all MAX_WIDTH * MAX_HEIGHT words (65536 with the default
// sizes); in_ready stays low during that pass, while configuration writes are
// taken at any time. An item whose centre lies outside the grid in use is taken
// and gives no results. Any other item updates n cells (1 to 9) and passes
// through an accept step that also starts the fertility product, five more
// steps through the single shared 32x24 multiplier (divide by five for the
// fertility, strength product, then three steps for the edge and diagonal
// weights), then one deposit step per cell, in which the read-modify-write of
// one cell overlaps the read of the next on the memory's one write and one read
// port.
// Results leave through an output register; a stalled output holds the cell
// sequence. The block is not ready for a new item until the last cell of the
// current one has been written.
module grid_neighbourhood_weighted_deposit #(
    parameter int unsigned MAX_WIDTH  = gnwd_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = gnwd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gnwd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gnwd_pkg::SIZE_W-1:0]             cfg_data,
    // deposit requests
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [gnwd_pkg::COORD_W-1:0]            cell_x,
    input  logic [gnwd_pkg::COORD_W-1:0]            cell_y,
    input  logic [gnwd_pkg::STRENGTH_W-1:0]         strength,
    input  logic signed [gnwd_pkg::FERT_W-1:0]      fertility,
    input  logic [gnwd_pkg::WATER_W-1:0]            water_supply,
    // updated cells
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [gnwd_pkg::COORD_W-1:0]            out_x,
    output logic [gnwd_pkg::COORD_W-1:0]            out_y,
    output logic [gnwd_pkg::DENSITY_W-1:0]          density,
    output logic                                    last
);

    localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned W_LIMIT = (MAX_WIDTH < gnwd_pkg::COORD_SPAN) ?
                                      MAX_WIDTH : gnwd_pkg::COORD_SPAN;
    localparam int unsigned H_LIMIT = (MAX_HEIGHT < gnwd_pkg::COORD_SPAN) ?
                                      MAX_HEIGHT : gnwd_pkg::COORD_SPAN;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EFF_Q,
        ST_EFF_B,
        ST_INC6A,
        ST_INC6B,
        ST_INC4,
        ST_DEPOSIT
    } state_t;

    // control state
    state_t                             state_reg, state_next;
    gnwd_pkg::slot_mask_t               mask_reg, mask_next;
    logic [gnwd_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [ADDR_W-1:0]                  clr_addr_reg, clr_addr_next;
    logic [gnwd_pkg::SIZE_W-1:0]        grid_width_reg, grid_width_next;
    logic [gnwd_pkg::SIZE_W-1:0]        grid_height_reg, grid_height_next;
    logic                               out_valid_reg, out_valid_next;
    logic [gnwd_pkg::COORD_W-1:0]       out_x_reg, out_x_next;
    logic [gnwd_pkg::COORD_W-1:0]       out_y_reg, out_y_next;
    logic [gnwd_pkg::DENSITY_W-1:0]     density_reg, density_next;
    logic                               last_reg, last_next;

    // datapath
    logic [gnwd_pkg::COORD_W-1:0]       x_reg;
    logic [gnwd_pkg::COORD_W-1:0]       y_reg;
    logic [gnwd_pkg::STRENGTH_W-1:0]    s_reg;
    logic [gnwd_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic                               sat_reg, sat_next;
    logic [gnwd_pkg::BASE_W-1:0]        base_reg, base_next;
    logic [gnwd_pkg::INC_W-1:0]         inc10_reg, inc10_next;
    logic [gnwd_pkg::INC_W-1:0]         inc6_reg, inc6_next;

    // shared multiplier
    logic [gnwd_pkg::MUL_A_W-1:0]       mul_a;
    logic [gnwd_pkg::MUL_B_W-1:0]       mul_b;
    logic [gnwd_pkg::PROD_W-1:0]        mul_result;

    // memory ports
    logic [gnwd_pkg::DENSITY_W-1:0]     density_mem [DEPTH];
    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_waddr;
    logic [gnwd_pkg::DENSITY_W-1:0]     mem_wdata;
    logic                               mem_re;
    logic [ADDR_W-1:0]                  mem_raddr;
    logic [gnwd_pkg::DENSITY_W-1:0]     mem_rdata_reg;

    // request decode
    logic [gnwd_pkg::SIZE_W-1:0]        width_eff;
    logic [gnwd_pkg::SIZE_W-1:0]        height_eff;
    logic                               in_range;
    logic                               edge_up, edge_down, edge_left, edge_right;
    logic [gnwd_pkg::EFF_W-1:0]         fert_pos;
    logic [gnwd_pkg::WATER_TERM_W-1:0]  water_term;
    logic [gnwd_pkg::EFF_W-1:0]         eff_val;
    logic [gnwd_pkg::Q_W-1:0]           eff_q;

    // cell sequencing
    gnwd_pkg::cell_t                    write_cell;
    gnwd_pkg::cell_t                    read_cell;
    logic [gnwd_pkg::SLOT_W-1:0]        read_slot;
    gnwd_pkg::slot_mask_t               read_bit;
    logic [31:0]                        write_addr_full;
    logic [31:0]                        read_addr_full;
    logic [gnwd_pkg::INC_W-1:0]         inc_sel;
    logic [gnwd_pkg::DENSITY_W:0]       sum_wide;
    logic [gnwd_pkg::DENSITY_W-1:0]     density_new;
    logic                               out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign density   = density_reg;
    assign last      = last_reg;

    assign mul_result = gnwd_pkg::PROD_W'(mul_a) * gnwd_pkg::PROD_W'(mul_b);
    assign out_free   = !out_valid_reg || out_ready;

    // grid size in use, zero counts as one
    always_comb
    begin
        width_eff  = (grid_width_reg == '0) ? gnwd_pkg::SIZE_W'(1) : grid_width_reg;
        height_eff = (grid_height_reg == '0) ? gnwd_pkg::SIZE_W'(1) : grid_height_reg;
        if (width_eff > gnwd_pkg::SIZE_W'(W_LIMIT))
        begin
            width_eff = gnwd_pkg::SIZE_W'(W_LIMIT);
        end
        if (height_eff > gnwd_pkg::SIZE_W'(H_LIMIT))
        begin
            height_eff = gnwd_pkg::SIZE_W'(H_LIMIT);
        end
    end

    // centre check and edge flags of the incoming request
    assign in_range   = (gnwd_pkg::SIZE_W'(cell_x) < width_eff) &&
                        (gnwd_pkg::SIZE_W'(cell_y) < height_eff);
    assign edge_up    = (cell_y != '0);
    assign edge_left  = (cell_x != '0);
    assign edge_down  = (gnwd_pkg::SIZE_W'(cell_y) + gnwd_pkg::SIZE_W'(1)) < height_eff;
    assign edge_right = (gnwd_pkg::SIZE_W'(cell_x) + gnwd_pkg::SIZE_W'(1)) < width_eff;

    // negative fertility clamps to zero
    assign fert_pos   = fertility[gnwd_pkg::FERT_W-1] ? '0 : fertility[gnwd_pkg::EFF_W-1:0];
    assign water_term = gnwd_pkg::WATER_TERM_W'(water_supply) + gnwd_pkg::EFF_DEN;

    assign eff_q   = prod_reg[gnwd_pkg::EFF_Q_SHIFT +: gnwd_pkg::Q_W];
    assign eff_val = sat_reg ? gnwd_pkg::EFF_ONE
                             : prod_reg[gnwd_pkg::RECIP5_19_SHIFT +: gnwd_pkg::EFF_W];

    // addresses of the cell being written and the next cell to read
    always_comb
    begin
        write_cell      = gnwd_pkg::slot_cell(slot_reg, x_reg, y_reg);
        read_slot       = gnwd_pkg::first_slot(mask_reg);
        read_cell       = gnwd_pkg::slot_cell(read_slot, x_reg, y_reg);
        read_bit        = gnwd_pkg::slot_mask_t'(1) << read_slot;
        write_addr_full = 32'(write_cell.row) * 32'(MAX_WIDTH) + 32'(write_cell.col);
        read_addr_full  = 32'(read_cell.row) * 32'(MAX_WIDTH) + 32'(read_cell.col);
        mem_raddr       = read_addr_full[ADDR_W-1:0];
    end

    // increment for the current slot, saturating add
    always_comb
    begin
        unique case (gnwd_pkg::slot_weight(slot_reg))
            gnwd_pkg::WT_CENTRE: inc_sel = inc10_reg;
            gnwd_pkg::WT_EDGE:   inc_sel = inc6_reg;
            gnwd_pkg::WT_DIAG:   inc_sel = prod_reg[gnwd_pkg::RECIP5_26_SHIFT +: gnwd_pkg::INC_W];
            default:             inc_sel = inc10_reg;
        endcase
        sum_wide    = {1'b0, mem_rdata_reg} + (gnwd_pkg::DENSITY_W + 1)'(inc_sel);
        density_new = sum_wide[gnwd_pkg::DENSITY_W] ? '1 : sum_wide[gnwd_pkg::DENSITY_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        mask_next        = mask_reg;
        slot_next        = slot_reg;
        clr_addr_next    = clr_addr_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        density_next     = density_reg;
        last_next        = last_reg;
        prod_next        = prod_reg;
        sat_next         = sat_reg;
        base_next        = base_reg;
        inc10_next       = inc10_reg;
        inc6_next        = inc6_reg;
        mul_a            = '0;
        mul_b            = '0;
        mem_we           = 1'b0;
        mem_waddr        = write_addr_full[ADDR_W-1:0];
        mem_wdata        = density_new;
        mem_re           = 1'b0;

        // register writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gnwd_pkg::REG_GRID_WIDTH:  grid_width_next  = cfg_data;
                gnwd_pkg::REG_GRID_HEIGHT: grid_height_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // f0 * (1280 + water)
                mul_a     = gnwd_pkg::MUL_A_W'(fert_pos);
                mul_b     = gnwd_pkg::MUL_B_W'(water_term);
                prod_next = mul_result;
                if (in_valid && in_range)
                begin
                    state_next = ST_EFF_Q;
                    mask_next  = gnwd_pkg::neighbour_mask(edge_up, edge_down,
                                                          edge_left, edge_right);
                end
            end
            ST_EFF_Q:
            begin
                // divide by 256 then by five, flag the 1.0 cap
                mul_a      = gnwd_pkg::MUL_A_W'(eff_q);
                mul_b      = gnwd_pkg::RECIP5_19;
                prod_next  = mul_result;
                sat_next   = (eff_q >= gnwd_pkg::EFF_SAT_Q);
                state_next = ST_EFF_B;
            end
            ST_EFF_B:
            begin
                // strength * effective fertility
                mul_a      = gnwd_pkg::MUL_A_W'(s_reg);
                mul_b      = gnwd_pkg::MUL_B_W'(eff_val);
                prod_next  = mul_result;
                state_next = ST_INC6A;
            end
            ST_INC6A:
            begin
                base_next  = prod_reg[gnwd_pkg::BASE_W-1:0];
                inc10_next = prod_reg[gnwd_pkg::BASE_W-1:gnwd_pkg::INC_SHIFT];
                mul_a      = gnwd_pkg::MUL_A_W'(prod_reg[gnwd_pkg::BASE_W-1:0]);
                mul_b      = gnwd_pkg::EDGE_TRIPLE;
                prod_next  = mul_result;
                state_next = ST_INC6B;
            end
            ST_INC6B:
            begin
                mul_a      = gnwd_pkg::MUL_A_W'(prod_reg[gnwd_pkg::INC_SHIFT +: gnwd_pkg::TRIPLE_W]);
                mul_b      = gnwd_pkg::RECIP5_26;
                prod_next  = mul_result;
                state_next = ST_INC4;
            end
            ST_INC4:
            begin
                // diagonal increment lands in prod_reg; centre read starts
                inc6_next  = prod_reg[gnwd_pkg::RECIP5_26_SHIFT +: gnwd_pkg::INC_W];
                mul_a      = gnwd_pkg::MUL_A_W'(base_reg[gnwd_pkg::BASE_W-1:gnwd_pkg::DIAG_SHIFT]);
                mul_b      = gnwd_pkg::RECIP5_26;
                prod_next  = mul_result;
                mem_re     = 1'b1;
                slot_next  = read_slot;
                mask_next  = mask_reg & ~read_bit;
                state_next = ST_DEPOSIT;
            end
            ST_DEPOSIT:
            begin
                // write back one cell and read the next while the output is free
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_x_next     = write_cell.col;
                    out_y_next     = write_cell.row;
                    density_next   = density_new;
                    last_next      = (mask_reg == '0);
                    if (mask_reg != '0)
                    begin
                        mem_re    = 1'b1;
                        slot_next = read_slot;
                        mask_next = mask_reg & ~read_bit;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            mask_reg        <= '0;
            slot_reg        <= gnwd_pkg::SLOT_CENTRE;
            clr_addr_reg    <= '0;
            grid_width_reg  <= gnwd_pkg::SIZE_RESET;
            grid_height_reg <= gnwd_pkg::SIZE_RESET;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            density_reg     <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mask_reg        <= mask_next;
            slot_reg        <= slot_next;
            clr_addr_reg    <= clr_addr_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            out_valid_reg   <= out_valid_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            density_reg     <= density_next;
            last_reg        <= last_next;
        end
    end

    // arithmetic registers and request capture
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        sat_reg   <= sat_next;
        base_reg  <= base_next;
        inc10_reg <= inc10_next;
        inc6_reg  <= inc6_next;
        if (in_valid && in_ready)
        begin
            x_reg <= cell_x;
            y_reg <= cell_y;
            s_reg <= strength;
        end
    end

    // density memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            density_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= density_mem[mem_raddr];
        end
    end

    // checks
    `GNWD_ASSERT_IMP(a_no_result_in_clear, state_reg == ST_CLEAR, !out_valid_reg)
    `GNWD_ASSERT_IMP(a_centre_first, state_reg == ST_DEPOSIT, !mask_reg[gnwd_pkg::SLOT_CENTRE])
    `GNWD_ASSERT_IMP(a_write_needs_slot, mem_we && state_reg == ST_DEPOSIT, out_free)
    `GNWD_ASSERT_NXT(a_no_gap_in_burst, out_valid && out_ready && !last, out_valid)

endmodule
